// ----- rtl/rth_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared widths, pipeline record types and the restoring division step.
// ----------------------------------------------------------------------------
package rth_pkg;

    // Hue resolution: hue is given in units of 1/2^HUE_FRAC_BITS degree.
    localparam int HUE_FRAC_BITS = 6;

    localparam int CH_W      = 8;
    localparam int HUE_OUT_W = 15;

    // Scale applied to |pos - neg| before division by delta.
    localparam int HUE_SCALE = 60 << HUE_FRAC_BITS;
    localparam int HQ_W      = $clog2(HUE_SCALE + 1);
    // Quotient bits per division: wide enough for hue and for saturation.
    localparam int DQ_W      = (HQ_W > CH_W) ? HQ_W : CH_W;
    // Division word: partial remainder on top, dividend / quotient below.
    localparam int DW        = CH_W + DQ_W;
    // Internal hue width before fitting to the output field.
    localparam int HW        = $clog2((360 << HUE_FRAC_BITS) + 1);

    localparam logic [HW-1:0] BASE_RED_WRAP = HW'(360 << HUE_FRAC_BITS);
    localparam logic [HW-1:0] BASE_GREEN    = HW'(120 << HUE_FRAC_BITS);
    localparam logic [HW-1:0] BASE_BLUE     = HW'(240 << HUE_FRAC_BITS);

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    // Record after the channel compare stage.
    typedef struct packed {
        logic              grey;
        logic              neg;
        sector_t           sector;
        logic [CH_W-1:0]   bright;
        logic [CH_W-1:0]   delta;
        logic [CH_W-1:0]   diff;
    } front_t;

    // Record carried through the division stages.
    typedef struct packed {
        logic              grey;
        logic              neg;
        sector_t           sector;
        logic [CH_W-1:0]   bright;
        logic [CH_W-1:0]   delta;
        logic [DW-1:0]     hz;
        logic [DW-1:0]     sz;
    } div_item_t;

    // One restoring division step on {remainder, dividend bits}.
    // The remainder stays below the divisor, so it fits in CH_W bits.
    function automatic logic [DW-1:0] div_step(input logic [DW-1:0]   z,
                                               input logic [CH_W-1:0] d);
        logic [CH_W:0]   t;
        logic            ge;
        logic [CH_W:0]   sub;
        logic [CH_W-1:0] rem;
        t   = {z[DW-1:DQ_W], z[DQ_W-1]};
        ge  = (t >= {1'b0, d});
        sub = t - {1'b0, d};
        rem = ge ? sub[CH_W-1:0] : t[CH_W-1:0];
        return {rem, z[DQ_W-2:0], ge};
    endfunction

endpackage

// ----- rtl/rth_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV stream interfaces
// Valid/ready channels for input pixels and HSV results.
// ----------------------------------------------------------------------------
interface rth_pixel_if
    import rth_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if
    import rth_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [HUE_OUT_W-1:0] hue;
    logic [CH_W-1:0]      saturation;
    logic [CH_W-1:0]      brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

// ----- rtl/rth_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two stages: channel max/min and sector pick, then dividend scaling.
// ----------------------------------------------------------------------------
module rth_front
    import rth_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [CH_W-1:0] red,
    input  logic [CH_W-1:0] green,
    input  logic [CH_W-1:0] blue,
    output logic            out_valid,
    output div_item_t       out_item
);

    localparam logic [DW-1:0] SCALE_W = DW'(HUE_SCALE);

    logic      s1_valid_reg;
    front_t    s1_reg;
    front_t    s1_next;
    logic      s2_valid_reg;
    div_item_t s2_reg;
    div_item_t s2_next;

    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] lo;
    logic [CH_W-1:0] pos;
    logic [CH_W-1:0] negv;

    // Stage 1: max, min, sector (red, green, blue on ties) and signed difference.
    always_comb
    begin
        hi = red;
        lo = red;
        if (green > hi)
        begin
            hi = green;
        end
        if (blue > hi)
        begin
            hi = blue;
        end
        if (green < lo)
        begin
            lo = green;
        end
        if (blue < lo)
        begin
            lo = blue;
        end

        priority if (hi == red)
        begin
            s1_next.sector = SEC_RED;
            pos            = green;
            negv           = blue;
        end
        else if (hi == green)
        begin
            s1_next.sector = SEC_GREEN;
            pos            = blue;
            negv           = red;
        end
        else
        begin
            s1_next.sector = SEC_BLUE;
            pos            = red;
            negv           = green;
        end

        s1_next.bright = hi;
        s1_next.delta  = hi - lo;
        s1_next.grey   = (hi == lo);
        s1_next.neg    = (pos < negv);
        s1_next.diff   = (pos < negv) ? (negv - pos) : (pos - negv);
    end

    // Stage 2: form the two dividends.
    always_comb
    begin
        s2_next.grey   = s1_reg.grey;
        s2_next.neg    = s1_reg.neg;
        s2_next.sector = s1_reg.sector;
        s2_next.bright = s1_reg.bright;
        s2_next.delta  = s1_reg.delta;
        s2_next.hz     = DW'(s1_reg.diff) * SCALE_W;
        s2_next.sz     = DW'({s1_reg.delta, 8'h00}) - DW'(s1_reg.delta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_reg;

endmodule

// ----- rtl/rth_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV division step
// One registered restoring step for both the hue and saturation quotients.
// ----------------------------------------------------------------------------
module rth_div_step
    import rth_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  div_item_t in_item,
    output logic      out_valid,
    output div_item_t out_item
);

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;

    always_comb
    begin
        item_next    = in_item;
        item_next.hz = div_step(in_item.hz, in_item.delta);
        item_next.sz = div_step(in_item.sz, in_item.bright);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- rtl/rth_finish.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV finish stage
// Adds the sector base to the hue quotient and holds the output register.
// ----------------------------------------------------------------------------
module rth_finish
    import rth_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  div_item_t            in_item,
    output logic                 out_valid,
    output logic [HUE_OUT_W-1:0] hue,
    output logic [CH_W-1:0]      saturation,
    output logic [CH_W-1:0]      brightness
);

    logic                 valid_reg;
    logic [HUE_OUT_W-1:0] hue_reg;
    logic [HUE_OUT_W-1:0] hue_next;
    logic [CH_W-1:0]      sat_reg;
    logic [CH_W-1:0]      sat_next;
    logic [CH_W-1:0]      bright_reg;

    logic [HW-1:0] base;
    logic [HW-1:0] quo;
    logic          rem_nz;
    logic [HW-1:0] hue_full;

    always_comb
    begin
        unique case (in_item.sector)
            SEC_RED:   base = in_item.neg ? BASE_RED_WRAP : '0;
            SEC_GREEN: base = BASE_GREEN;
            SEC_BLUE:  base = BASE_BLUE;
            default:   base = '0;
        endcase

        quo    = HW'(in_item.hz[DQ_W-1:0]);
        rem_nz = |in_item.hz[DW-1:DQ_W];

        // Negative offset: floor(base - x/delta) = base - ceil(x/delta).
        if (in_item.neg)
        begin
            hue_full = base - quo - HW'(rem_nz);
        end
        else
        begin
            hue_full = base + quo;
        end

        if (in_item.grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = HUE_OUT_W'(hue_full);
            sat_next = in_item.sz[CH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= in_item.bright;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

// ----- rtl/rgb_to_hsv_convert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Streams 8-bit RGB pixels in and HSV results out at one pixel per clock when the hsv side does not stall.
// ----------------------------------------------------------------------------
// Each request on the pixel channel carries one red/green/blue pixel and
// yields exactly one request on the hsv channel, in order. Brightness is the
// largest channel, saturation is floor(255*delta/max) and hue is the floor of
// the exact hue in 1/64 degree (0 up to below 360 degrees); a grey pixel gives
// hue and saturation of zero. When channels tie for the maximum, the sector is
// picked as red, then green, then blue. The block accepts a new pixel every
// clock while the hsv side does not stall; the pipeline has one stage
// for max/min and sector, one to scale the dividends, one stage per quotient
// bit of the two shared-step restoring dividers, and the output register.
// The whole pipeline moves as one: it advances whenever the output register is
// empty or its result is being taken, so a stall on the hsv side holds every
// stage in place and drops nothing.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert
    import rth_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rth_pixel_if.sink   pixel,
    rth_hsv_if.source   hsv
);

    logic      adv;
    logic      div_valid [DQ_W+1];
    div_item_t div_item  [DQ_W+1];

    // Advance everything when the result slot is free or being drained.
    assign adv         = !hsv.valid || hsv.ready;
    assign pixel.ready = adv;

    // Channel compare and dividend scaling.
    rth_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pixel.valid),
        .red       (pixel.red),
        .green     (pixel.green),
        .blue      (pixel.blue),
        .out_valid (div_valid[0]),
        .out_item  (div_item[0])
    );

    // One quotient bit per stage for hue and saturation in parallel.
    for (genvar i = 0; i < DQ_W; i++)
    begin : g_div
        rth_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (div_valid[i]),
            .in_item   (div_item[i]),
            .out_valid (div_valid[i+1]),
            .out_item  (div_item[i+1])
        );
    end

    // Sector base, grey override and output register.
    rth_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (div_valid[DQ_W]),
        .in_item    (div_item[DQ_W]),
        .out_valid  (hsv.valid),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness)
    );

endmodule

// ----- tb/rgb_to_hsv_convert_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Streams corner-case and random pixels through the converter under several
// sender and receiver stall patterns. A scoreboard predicts hue, saturation
// and brightness for every accepted pixel and checks each result in order.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_tb
    import rth_pkg::*;
();

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    // Pipeline depth as documented at the head of the converter.
    localparam int LATENCY      = DQ_W + 3;
    localparam int SETTLE_CYCLES = 4 * LATENCY;
    // Far above the slowest legal run of 1222 requests.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_CORNERS  = 22;

    // Hue geometry in whole degrees.
    localparam int unsigned DEG_PER_SECTOR = 60;
    localparam int unsigned DEG_GREEN      = 120;
    localparam int unsigned DEG_BLUE       = 240;
    localparam int unsigned DEG_FULL       = 360;
    localparam int unsigned CH_FULL        = 255;

    typedef struct packed {
        logic [CH_W-1:0]      red;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      blue;
        logic [HUE_OUT_W-1:0] hue;
        logic [CH_W-1:0]      saturation;
        logic [CH_W-1:0]      brightness;
    } hsv_expect_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predict HSV per accepted pixel, match results in order
    // ------------------------------------------------------------------------
    class hsv_scoreboard;
        hsv_expect_t pending[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function hsv_expect_t predict_hsv(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                          logic [CH_W-1:0] b);
            int unsigned hi;
            int unsigned lo;
            int unsigned delta;
            int unsigned base;
            int unsigned pos;
            int unsigned neg;
            int unsigned num;
            sector_t     sec;
            hsv_expect_t res;
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            delta = hi - lo;
            res.red        = r;
            res.green      = g;
            res.blue       = b;
            res.brightness = CH_W'(hi);
            res.hue        = '0;
            res.saturation = '0;
            if (delta != 0)
            begin
                if (hi == r)      sec = SEC_RED;
                else if (hi == g) sec = SEC_GREEN;
                else              sec = SEC_BLUE;
                case (sec)
                    SEC_RED:
                    begin
                        pos  = g;
                        neg  = b;
                        base = (g >= b) ? 0 : DEG_FULL;
                    end
                    SEC_GREEN:
                    begin
                        pos  = b;
                        neg  = r;
                        base = DEG_GREEN;
                    end
                    default:
                    begin
                        pos  = r;
                        neg  = g;
                        base = DEG_BLUE;
                    end
                endcase
                num = (base * delta + DEG_PER_SECTOR * pos - DEG_PER_SECTOR * neg)
                      << HUE_FRAC_BITS;
                res.hue        = HUE_OUT_W'(num / delta);
                res.saturation = CH_W'((CH_FULL * delta) / hi);
            end
            return res;
        endfunction

        function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                 logic [CH_W-1:0] b);
            pending.push_back(predict_hsv(r, g, b));
        endfunction

        function void report(string field, int unsigned want, int unsigned got,
                             hsv_expect_t e);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch for rgb(%0d,%0d,%0d): expected %0d, got %0d",
                         $realtime, field, e.red, e.green, e.blue, want, got);
        endfunction

        function void check_result(logic [HUE_OUT_W-1:0] hue, logic [CH_W-1:0] sat,
                                   logic [CH_W-1:0] bright);
            hsv_expect_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result hue=%0d sat=%0d bright=%0d",
                             $realtime, hue, sat, bright);
                return;
            end
            e = pending.pop_front();
            if (hue !== e.hue)           report("hue", e.hue, hue, e);
            if (sat !== e.saturation)    report("saturation", e.saturation, sat, e);
            if (bright !== e.brightness) report("brightness", e.brightness, bright, e);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   cycle_count;

    rth_pixel_if pixel_ch();
    rth_hsv_if   hsv_ch();

    hsv_scoreboard sb = new();

    // Named corners: grey levels, primaries, every two-way and three-way tie,
    // red-sector wrap past 360, delta of one and the smallest nonzero pixels.
    logic [3*CH_W-1:0] corner_pixels [NUM_CORNERS] = '{
        24'h000000, 24'hffffff, 24'h808080, 24'h010101,
        24'hff0000, 24'h00ff00, 24'h0000ff,
        24'hffff00, 24'h00ffff, 24'hff00ff,
        24'hff0001, 24'hff0100, 24'hff00fe, 24'h010000,
        24'hfffefe, 24'h000101, 24'hfeff00, 24'h00feff,
        24'h0100ff, 24'h0a7f7f, 24'h7f0a7f, 24'h55aaff
    };

    rgb_to_hsv_convert uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .hsv   (hsv_ch)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver: hold off ready at random according to the current stall rate.
    initial
    begin
        hsv_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            hsv_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Observe both channels at the edge; values seen here are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
            sb.note_pixel(pixel_ch.red, pixel_ch.green, pixel_ch.blue);
        if (rst_n && hsv_ch.valid && hsv_ch.ready)
            sb.check_result(hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness);
    end

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $realtime,
                     sb.pending.size());
            $display("rgb_to_hsv_convert_tb failed");
            $finish;
        end
    end

    // Present one pixel, idling first at the current rate, and hold it until
    // the converter takes the request. Valid stays high on return so that a
    // back-to-back request needs no second assignment in the same step.
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.red   <= r;
        pixel_ch.green <= g;
        pixel_ch.blue  <= b;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
    endtask

    // Drop valid and wait until every accepted pixel has its result.
    task automatic drain_results();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Random pixel, biased toward grey, ties and channel extremes.
    task automatic send_random_pixel();
        logic [CH_W-1:0] ch [3];
        logic [CH_W-1:0] v;
        int              pick;
        int              k;
        pick = $urandom_range(9);
        for (k = 0; k < 3; k++)
            ch[k] = CH_W'($urandom);
        case (pick)
            0:
            begin
                // grey pixel
                ch[1] = ch[0];
                ch[2] = ch[0];
            end
            1:
            begin
                // two channels tie at the maximum
                v = ch[0];
                k = $urandom_range(2);
                ch[k]           = CH_W'($urandom_range(v));
                ch[(k + 1) % 3] = v;
                ch[(k + 2) % 3] = v;
            end
            2:
            begin
                // two channels tie at the minimum
                v = ch[0];
                k = $urandom_range(2);
                ch[k]           = CH_W'($urandom_range(CH_FULL, v));
                ch[(k + 1) % 3] = v;
                ch[(k + 2) % 3] = v;
            end
            3:
            begin
                // channels at or next to the rails
                for (k = 0; k < 3; k++)
                    case ($urandom_range(3))
                        0: ch[k] = '0;
                        1: ch[k] = 8'd1;
                        2: ch[k] = 8'd254;
                        default: ch[k] = '1;
                    endcase
            end
            default: ;
        endcase
        send_pixel(ch[0], ch[1], ch[2]);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        int i;
        int phase_idle [4];
        int phase_stall [4];
        phase_idle  = '{0, 82, 0, 35};
        phase_stall = '{0, 0, 82, 35};
        cycle_count    = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        rst_n          = 1'b0;
        pixel_ch.valid = 1'b0;
        pixel_ch.red   = '0;
        pixel_ch.green = '0;
        pixel_ch.blue  = '0;

        // Hold reset, then release on an edge.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners first, back to back with no stalls.
        for (i = 0; i < NUM_CORNERS; i++)
            send_pixel(corner_pixels[i][23:16], corner_pixels[i][15:8],
                       corner_pixels[i][7:0]);
        drain_results();

        // Random traffic under each stall pattern; halfway through a phase,
        // pause the sender until the pipeline is empty.
        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct  = phase_idle[phase];
            stall_pct = phase_stall[phase];
            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (i == RANDOM_PER_PHASE / 2)
                    drain_results();
                send_random_pixel();
            end
        end

        // Let all results out, then watch a while longer for strays.
        drain_results();
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("rgb_to_hsv_convert_tb passed");
        else
            $display("rgb_to_hsv_convert_tb failed");
        $finish;
    end

endmodule

// ----- rgb_to_hsv_convert.f -----
rtl/rth_pkg.sv
rtl/rth_ifs.sv
rtl/rth_front.sv
rtl/rth_div_step.sv
rtl/rth_finish.sv
rtl/rgb_to_hsv_convert.sv
tb/rgb_to_hsv_convert_tb.sv
